// ===== rtl/core/lcdns_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_pkg
// Types, constants and the power-up table shared by the character LCD
// nibble sequencer front end, job queue and back end.
// ----------------------------------------------------------------------------
package lcdns_pkg;

    // Request codes on the action field
    typedef enum logic [1:0] {
        ACT_INIT   = 2'd0,
        ACT_CMD    = 2'd1,
        ACT_DATA   = 2'd2,
        ACT_CURSOR = 2'd3
    } t_action;

    // Kind of job handed from the front end to the back end
    typedef enum logic [1:0] {
        JOB_ERROR = 2'd0,
        JOB_INIT  = 2'd1,
        JOB_BYTE  = 2'd2
    } t_job_kind;

    // One classified transaction; for init, byte_val holds the function-set byte
    typedef struct packed {
        t_job_kind  kind;
        logic       rs;
        logic [7:0] byte_val;
        logic       long_wait;
    } t_job;

    // One nibble write or error report
    typedef struct packed {
        logic        drive_valid;
        logic        reg_select;
        logic [3:0]  nibble;
        logic [15:0] settle_before_us;
        logic [12:0] wait_after_us;
        logic        status;
        logic        last;
    } t_result;

    // One row of the power-up table
    typedef struct packed {
        logic [3:0]  nibble;
        logic [15:0] settle_us;
        logic [12:0] wait_us;
    } t_init_entry;

    // Register map (decoded on paddr[2])
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [2:0] ROWS_RESET = 3'd2;
    localparam logic [5:0] COLS_RESET = 6'd16;
    localparam logic [2:0] KNOWN_ROWS = 3'd4;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] FS_ONE_LINE   = 8'h20;
    localparam logic [7:0] FS_TWO_LINE   = 8'h28;

    // Start address of each row; element 0 is row 0
    localparam logic [3:0][7:0] ROW_BASE = {8'h54, 8'h14, 8'h40, 8'h00};

    localparam logic [12:0] CMD_WAIT_US   = 13'd40;
    localparam logic [12:0] CLEAR_WAIT_US = 13'd2040;
    localparam logic [15:0] NO_SETTLE_US  = 16'd0;

    localparam logic [3:0] INIT_FS_LOW_STEP = 4'd5;
    localparam logic [3:0] INIT_LAST_STEP   = 4'd11;

    // Power-up sequence; the function-set low nibble is patched in by the back end
    function automatic t_init_entry init_entry(input logic [3:0] step);
        t_init_entry e;
        e.settle_us = NO_SETTLE_US;
        e.wait_us   = CMD_WAIT_US;
        unique case (step)
            4'd0: begin
                e.nibble    = 4'h3;
                e.settle_us = 16'd50000;
                e.wait_us   = 13'd5040;
            end
            4'd1: begin
                e.nibble  = 4'h3;
                e.wait_us = 13'd190;
            end
            4'd2: begin
                e.nibble  = 4'h3;
                e.wait_us = 13'd80;
            end
            4'd3: begin
                e.nibble  = 4'h2;
                e.wait_us = 13'd80;
            end
            4'd4:  e.nibble = 4'h2;
            4'd5:  e.nibble = 4'h0;
            4'd6:  e.nibble = 4'h0;
            4'd7:  e.nibble = 4'hC;
            4'd8:  e.nibble = 4'h0;
            4'd9: begin
                e.nibble  = 4'h1;
                e.wait_us = 13'd3040;
            end
            4'd10: e.nibble = 4'h0;
            4'd11: e.nibble = 4'h6;
            default: e.nibble = 4'h0;
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lcdns_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_front
// Holds the configuration registers behind the APB-style port and turns each
// accepted request into a job: error, power-up sequence or one byte write.
// ----------------------------------------------------------------------------
module lcdns_front
    import lcdns_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic [5:0]  i_cursor_col,
    input  wire logic [2:0]  i_cursor_row,
    output t_job             o_job
);

    logic [2:0] r_rows;
    logic [5:0] r_cols;
    logic       cfg_write;
    logic [7:0] cursor_sum;

    // Write configuration on the access phase
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
            r_cols <= COLS_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_ROWS) begin
                r_rows <= pwdata[2:0];
            end else begin
                r_cols <= pwdata[5:0];
            end
        end
    end

    // Read back the addressed register
    always_comb begin
        if (paddr[2] == REG_ROWS) begin
            prdata = {29'd0, r_rows};
        end else begin
            prdata = {26'd0, r_cols};
        end
    end

    // DDRAM address for set cursor, wrapped to eight bits
    assign cursor_sum = ROW_BASE[i_cursor_row[1:0]] + {2'd0, i_cursor_col};

    // Classify the request
    always_comb begin
        o_job.kind      = JOB_BYTE;
        o_job.rs        = 1'b0;
        o_job.byte_val  = i_byte_value;
        o_job.long_wait = 1'b0;
        unique case (t_action'(i_action))
            ACT_INIT: begin
                if (r_rows == 3'd0 || r_cols == 6'd0) begin
                    o_job.kind = JOB_ERROR;
                end else begin
                    o_job.kind = JOB_INIT;
                end
                o_job.byte_val = (r_rows > 3'd1) ? FS_TWO_LINE : FS_ONE_LINE;
            end
            ACT_CMD: begin
                o_job.long_wait = (i_byte_value == CMD_CLEAR) ||
                                  (i_byte_value == CMD_HOME);
            end
            ACT_DATA: begin
                o_job.rs = 1'b1;
            end
            ACT_CURSOR: begin
                if (i_cursor_row >= r_rows || i_cursor_col >= r_cols ||
                    i_cursor_row >= KNOWN_ROWS) begin
                    o_job.kind = JOB_ERROR;
                end
                o_job.byte_val = CMD_SET_DDRAM | cursor_sum;
            end
            default: o_job.kind = JOB_ERROR;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/lcdns_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_queue
// Short first-in first-out queue of jobs between the front end and the
// nibble sequencer; the head entry is presented combinationally, with no read step.
// ----------------------------------------------------------------------------
module lcdns_queue
    import lcdns_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output t_job      o_head,
    output logic      o_empty,
    output logic      o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Store the incoming job
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lcdns_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_back
// Nibble sequencer: while the queue holds a job, walks the head job one
// result (nibble write or error report) per clock and registers each result
// with its strobe; drops the job after its last result.
module lcdns_back
    import lcdns_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_job      i_head,
    input  wire logic i_empty,
    output logic      o_pop,
    output logic      o_strobe,
    output t_result   o_result
);

    logic [3:0]  r_step;
    logic        r_strobe;
    t_result     r_result;
    t_result     cur;
    t_init_entry entry;
    logic        done;

    // Build the result for the current step of the head job
    always_comb begin
        entry                = init_entry(r_step);
        cur.drive_valid      = 1'b1;
        cur.reg_select       = i_head.rs;
        cur.nibble           = 4'h0;
        cur.settle_before_us = NO_SETTLE_US;
        cur.wait_after_us    = CMD_WAIT_US;
        cur.status           = 1'b0;
        done                 = 1'b0;
        unique case (i_head.kind)
            JOB_ERROR: begin
                cur.drive_valid   = 1'b0;
                cur.reg_select    = 1'b0;
                cur.wait_after_us = 13'd0;
                cur.status        = 1'b1;
                done              = 1'b1;
            end
            JOB_INIT: begin
                cur.reg_select       = 1'b0;
                cur.nibble           = (r_step == INIT_FS_LOW_STEP) ?
                                       i_head.byte_val[3:0] : entry.nibble;
                cur.settle_before_us = entry.settle_us;
                cur.wait_after_us    = entry.wait_us;
                done                 = (r_step == INIT_LAST_STEP);
            end
            JOB_BYTE: begin
                cur.nibble = r_step[0] ? i_head.byte_val[3:0] : i_head.byte_val[7:4];
                if (r_step[0] && i_head.long_wait) begin
                    cur.wait_after_us = CLEAR_WAIT_US;
                end
                done = r_step[0];
            end
            default: begin
                cur.drive_valid   = 1'b0;
                cur.reg_select    = 1'b0;
                cur.wait_after_us = 13'd0;
                cur.status        = 1'b1;
                done              = 1'b1;
            end
        endcase
        cur.last = done;
    end

    assign o_pop = !i_empty && done;

    // Advance the step counter and hold the strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= 4'd0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= !i_empty;
            if (!i_empty) begin
                r_step <= done ? 4'd0 : r_step + 4'd1;
            end
        end
    end

    // Register the payload
    always_ff @(posedge i_clk) begin
        if (!i_empty) begin
            r_result <= cur;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== rtl/core/char_lcd_nibble_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Turns character LCD requests into nibble writes with RS level and waits.
// ----------------------------------------------------------------------------
// A request is taken on start while busy is low and is queued; the sequencer
// then puts out one result per clock, each marked by o_strobe for a single
// cycle, so the receiver must take every result as it comes. A command, data
// or set-cursor request gives two results, the power-up request twelve and a
// rejected request one error result. With an idle sequencer an accepted job
// passes through its queue entry and then the result register before its
// first result reaches the ports. busy rises only while the job queue is full,
// so byte requests can be issued back to back while busy is low; each byte
// gives two results from the one-nibble-per-clock sequencer.
module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic [5:0]  i_cursor_col,
    input  wire logic [2:0]  i_cursor_row,
    output logic             o_strobe,
    output logic             o_drive_valid,
    output logic             o_reg_select,
    output logic      [3:0]  o_nibble,
    output logic      [15:0] o_settle_before_us,
    output logic      [12:0] o_wait_after_us,
    output logic             o_status,
    output logic             o_last
);

    t_job    new_job;
    t_job    head_job;
    logic    q_empty;
    logic    q_full;
    logic    q_pop;
    t_result result;

    assign pready = 1'b1;
    assign busy   = q_full;

    // Classify requests and hold configuration
    lcdns_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .i_cursor_col (i_cursor_col),
        .i_cursor_row (i_cursor_row),
        .o_job        (new_job)
    );

    // Buffer jobs between the two sides
    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start),
        .i_job   (new_job),
        .i_pop   (q_pop),
        .o_head  (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Sequence nibble writes
    lcdns_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_job),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .o_strobe (o_strobe),
        .o_result (result)
    );

    assign o_drive_valid      = result.drive_valid;
    assign o_reg_select       = result.reg_select;
    assign o_nibble           = result.nibble;
    assign o_settle_before_us = result.settle_before_us;
    assign o_wait_after_us    = result.wait_after_us;
    assign o_status           = result.status;
    assign o_last             = result.last;

endmodule
`default_nettype wire
